@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ design/qsu_pkg.sv @@
// ----------------------------------------------------------------------------
// qsu_pkg
// types and constants for the quoted string unescaper
// ----------------------------------------------------------------------------
package qsu_pkg;

   typedef enum logic [2:0] {
      PH_OPEN = 3'd0,
      PH_BODY = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX  = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_NO_OPEN      = 3'd1;
   localparam logic [2:0] ERR_UNTERMINATED = 3'd2;
   localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd3;
   localparam logic [2:0] ERR_SHORT_UNI    = 3'd4;
   localparam logic [2:0] ERR_NON_HEX      = 3'd5;
   localparam logic [2:0] ERR_NOT_SCALAR   = 3'd6;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_LOW_B     = 8'h62;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_R     = 8'h72;
   localparam logic [7:0] CH_LOW_T     = 8'h74;
   localparam logic [7:0] CH_LOW_U     = 8'h75;
   localparam logic [7:0] CH_UP_U      = 8'h55;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;

   localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
   localparam logic [31:0] CP_SURR_LO   = 32'h0000_D800;
   localparam logic [31:0] CP_SURR_HI   = 32'h0000_DFFF;
   localparam logic [31:0] CP_LIM_1     = 32'h0000_0080;
   localparam logic [31:0] CP_LIM_2     = 32'h0000_0800;
   localparam logic [31:0] CP_LIM_3     = 32'h0001_0000;

   localparam logic [3:0] DIGITS_SHORT = 4'd4;
   localparam logic [3:0] DIGITS_LONG  = 4'd8;

   localparam int unsigned BURST_MAX = 4;

endpackage

@@ design/quoted_string_unescape_utf8.sv @@
// ----------------------------------------------------------------------------
// quoted_string_unescape_utf8
// decodes one double-quoted basic string, byte by byte, into utf-8 bytes
// ----------------------------------------------------------------------------
// One source byte is taken per clock through an input register, unless a busy
// result buffer holds the input, and is decoded in a single pass into a result
// buffer of up to four entries. Items that give no result or one result
// sustain one item per cycle while rsp_ready is high; a unicode escape that
// ends in an n-byte utf-8 sequence holds the result channel until all n bytes
// drain, one entry per cycle while rsp_ready is high, and the input register
// still takes the following item.
`include "assert_macros.svh"

module quoted_string_unescape_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_result_kind,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // decode state
   qsu_pkg::phase_type phase_ff, phase_in;
   logic [3:0]         digits_left_ff, digits_left_in;
   logic [31:0]        code_accum_ff, code_accum_in;

   // result buffer
   logic [7:0]        buf_byte_ff [qsu_pkg::BURST_MAX];
   logic [7:0]        buf_byte_in [qsu_pkg::BURST_MAX];
   qsu_pkg::kind_type buf_kind_ff, buf_kind_in;
   logic [2:0]        buf_err_ff, buf_err_in;
   logic [2:0]        cnt_ff, cnt_in;

   // single-pass decode results
   logic [2:0]        nres;
   qsu_pkg::kind_type res_kind;
   logic [2:0]        res_err;
   logic [7:0]        res_byte [qsu_pkg::BURST_MAX];

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [31:0] acc_shift;
   logic [3:0]  dl_dec;
   logic        bad_cp;

   logic rsp_fire, buf_free, advance, load, req_fire;

   assign rsp_valid       = (cnt_ff != 3'd0);
   assign rsp_out_byte    = buf_byte_ff[0];
   assign rsp_result_kind = buf_kind_ff;
   assign rsp_error_code  = buf_err_ff;
   assign rsp_last        = (cnt_ff == 3'd1);

   assign rsp_fire  = rsp_valid && rsp_ready;
   assign buf_free  = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_ready);
   assign advance   = in_valid_ff && (buf_free || (nres == 3'd0));
   assign load      = advance && (nres != 3'd0);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // hex digit decode
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte_ff >= 8'h30 && in_byte_ff <= 8'h39) begin
         hex_val = in_byte_ff[3:0];
      end else if ((in_byte_ff >= 8'h61 && in_byte_ff <= 8'h66) ||
                   (in_byte_ff >= 8'h41 && in_byte_ff <= 8'h46)) begin
         hex_val = in_byte_ff[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_shift = {code_accum_ff[27:0], hex_val};
   assign dl_dec    = (digits_left_ff != 4'd0) ? (digits_left_ff - 4'd1) : 4'd0;
   assign bad_cp    = (acc_shift > qsu_pkg::CP_MAX) ||
                      ((acc_shift >= qsu_pkg::CP_SURR_LO) &&
                       (acc_shift <= qsu_pkg::CP_SURR_HI));

   // next state and results for the item in the input register
   always_comb begin
      phase_in       = phase_ff;
      digits_left_in = digits_left_ff;
      code_accum_in  = code_accum_ff;
      nres           = 3'd0;
      res_kind       = qsu_pkg::KIND_DATA;
      res_err        = qsu_pkg::ERR_NONE;
      for (int i = 0; i < qsu_pkg::BURST_MAX; i++) begin
         res_byte[i] = 8'h00;
      end

      case (phase_ff)
         qsu_pkg::PH_BODY: begin
            if (in_end_ff || in_byte_ff == qsu_pkg::CH_NEWLINE) begin
               nres = 3'd1; res_kind = qsu_pkg::KIND_ERROR;
               res_err = qsu_pkg::ERR_UNTERMINATED;
               phase_in = qsu_pkg::PH_OPEN; digits_left_in = 4'd0;
               code_accum_in = 32'd0;
            end else if (in_byte_ff == qsu_pkg::CH_QUOTE) begin
               nres = 3'd1; res_kind = qsu_pkg::KIND_CLOSE;
               phase_in = qsu_pkg::PH_OPEN;
            end else if (in_byte_ff == qsu_pkg::CH_BACKSLASH) begin
               phase_in = qsu_pkg::PH_ESC;
            end else begin
               nres = 3'd1; res_byte[0] = in_byte_ff;
            end
         end
         qsu_pkg::PH_ESC: begin
            if (in_end_ff) begin
               nres = 3'd1; res_kind = qsu_pkg::KIND_ERROR;
               res_err = qsu_pkg::ERR_UNTERMINATED;
               phase_in = qsu_pkg::PH_OPEN; digits_left_in = 4'd0;
               code_accum_in = 32'd0;
            end else begin
               phase_in = qsu_pkg::PH_BODY;
               nres = 3'd1;
               case (in_byte_ff)
                  qsu_pkg::CH_QUOTE:     res_byte[0] = qsu_pkg::CH_QUOTE;
                  qsu_pkg::CH_BACKSLASH: res_byte[0] = qsu_pkg::CH_BACKSLASH;
                  qsu_pkg::CH_LOW_B:     res_byte[0] = qsu_pkg::CH_BS;
                  qsu_pkg::CH_LOW_F:     res_byte[0] = qsu_pkg::CH_FF;
                  qsu_pkg::CH_LOW_N:     res_byte[0] = qsu_pkg::CH_NEWLINE;
                  qsu_pkg::CH_LOW_R:     res_byte[0] = qsu_pkg::CH_CR;
                  qsu_pkg::CH_LOW_T:     res_byte[0] = qsu_pkg::CH_TAB;
                  qsu_pkg::CH_LOW_U: begin
                     nres = 3'd0; phase_in = qsu_pkg::PH_HEX;
                     digits_left_in = qsu_pkg::DIGITS_SHORT; code_accum_in = 32'd0;
                  end
                  qsu_pkg::CH_UP_U: begin
                     nres = 3'd0; phase_in = qsu_pkg::PH_HEX;
                     digits_left_in = qsu_pkg::DIGITS_LONG; code_accum_in = 32'd0;
                  end
                  default: begin
                     res_kind = qsu_pkg::KIND_ERROR;
                     res_err = qsu_pkg::ERR_BAD_ESCAPE;
                     phase_in = qsu_pkg::PH_OPEN; digits_left_in = 4'd0;
                     code_accum_in = 32'd0;
                  end
               endcase
            end
         end
         qsu_pkg::PH_HEX: begin
            if (in_end_ff || !hex_ok) begin
               nres = 3'd1; res_kind = qsu_pkg::KIND_ERROR;
               res_err = in_end_ff ? qsu_pkg::ERR_SHORT_UNI : qsu_pkg::ERR_NON_HEX;
               phase_in = qsu_pkg::PH_OPEN; digits_left_in = 4'd0;
               code_accum_in = 32'd0;
            end else if (dl_dec != 4'd0) begin
               digits_left_in = dl_dec;
               code_accum_in  = acc_shift;
            end else if (bad_cp) begin
               nres = 3'd1; res_kind = qsu_pkg::KIND_ERROR;
               res_err = qsu_pkg::ERR_NOT_SCALAR;
               phase_in = qsu_pkg::PH_OPEN; digits_left_in = 4'd0;
               code_accum_in = 32'd0;
            end else begin
               phase_in = qsu_pkg::PH_BODY;
               digits_left_in = 4'd0;
               code_accum_in = 32'd0;
               if (acc_shift < qsu_pkg::CP_LIM_1) begin
                  nres = 3'd1;
                  res_byte[0] = acc_shift[7:0];
               end else if (acc_shift < qsu_pkg::CP_LIM_2) begin
                  nres = 3'd2;
                  res_byte[0] = {3'b110, acc_shift[10:6]};
                  res_byte[1] = {2'b10, acc_shift[5:0]};
               end else if (acc_shift < qsu_pkg::CP_LIM_3) begin
                  nres = 3'd3;
                  res_byte[0] = {4'b1110, acc_shift[15:12]};
                  res_byte[1] = {2'b10, acc_shift[11:6]};
                  res_byte[2] = {2'b10, acc_shift[5:0]};
               end else begin
                  nres = 3'd4;
                  res_byte[0] = {5'b11110, acc_shift[20:18]};
                  res_byte[1] = {2'b10, acc_shift[17:12]};
                  res_byte[2] = {2'b10, acc_shift[11:6]};
                  res_byte[3] = {2'b10, acc_shift[5:0]};
               end
            end
         end
         default: begin
            if (in_end_ff || in_byte_ff != qsu_pkg::CH_QUOTE) begin
               nres = 3'd1; res_kind = qsu_pkg::KIND_ERROR;
               res_err = qsu_pkg::ERR_NO_OPEN;
               phase_in = qsu_pkg::PH_OPEN; digits_left_in = 4'd0;
               code_accum_in = 32'd0;
            end else begin
               phase_in = qsu_pkg::PH_BODY;
            end
         end
      endcase
   end

   // input register and result buffer next values
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      cnt_in      = cnt_ff;
      buf_kind_in = buf_kind_ff;
      buf_err_in  = buf_err_ff;
      for (int i = 0; i < qsu_pkg::BURST_MAX; i++) begin
         buf_byte_in[i] = buf_byte_ff[i];
      end
      if (load) begin
         cnt_in      = nres;
         buf_kind_in = res_kind;
         buf_err_in  = res_err;
         for (int i = 0; i < qsu_pkg::BURST_MAX; i++) begin
            buf_byte_in[i] = res_byte[i];
         end
      end else if (rsp_fire) begin
         cnt_in = cnt_ff - 3'd1;
         for (int i = 0; i < qsu_pkg::BURST_MAX - 1; i++) begin
            buf_byte_in[i] = buf_byte_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         phase_ff       <= qsu_pkg::PH_OPEN;
         digits_left_ff <= 4'd0;
         code_accum_ff  <= 32'd0;
         cnt_ff         <= 3'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         if (advance) begin
            phase_ff       <= phase_in;
            digits_left_ff <= digits_left_in;
            code_accum_ff  <= code_accum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_end_of_input;
      end
      buf_kind_ff <= buf_kind_in;
      buf_err_ff  <= buf_err_in;
      for (int i = 0; i < qsu_pkg::BURST_MAX; i++) begin
         buf_byte_ff[i] <= buf_byte_in[i];
      end
   end

   // assertions
   `ASSERT_IMPLIES(a_single_status, clock, reset, (cnt_ff != 3'd0) && (buf_kind_ff != qsu_pkg::KIND_DATA), cnt_ff == 3'd1)
   `ASSERT_NEXT(a_error_reopens, clock, reset, load && (res_kind == qsu_pkg::KIND_ERROR), phase_ff == qsu_pkg::PH_OPEN)
   `ASSERT_NEXT(a_hex_pending, clock, reset, advance && (nres == 3'd0) && (phase_ff == qsu_pkg::PH_HEX), (phase_ff == qsu_pkg::PH_HEX) && (digits_left_ff != 4'd0))

endmodule
